>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the tag stripper.
// Needs nothing else; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HTS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define HTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/hts_pkg.sv
// Shared types, character codes and match tables of the tag stripper.
// Depends on nothing; used by hts_csr, hts_core and html_tag_stripper.
`default_nettype none

package hts_pkg;

   localparam int PAT_COUNT = 6;
   localparam int PAT_SLOTS = 8;

   localparam logic [7:0] CHR_LT   = 8'h3C;
   localparam logic [7:0] CHR_GT   = 8'h3E;
   localparam logic [7:0] CHR_AMP  = 8'h26;
   localparam logic [7:0] CHR_SEMI = 8'h3B;
   localparam logic [7:0] CHR_NL   = 8'h0A;
   localparam logic [7:0] CHR_UC_A = 8'h41;
   localparam logic [7:0] CHR_UC_Z = 8'h5A;
   localparam logic [7:0] CASE_BIT = 8'h20;

   localparam logic [2:0] LEN_MAX = 3'd7;

   // Pattern order: br, amp, nbsp, lt, gt, quot
   localparam int PAT_BR = 0;

   localparam logic [7:0] PAT_TEXT [PAT_COUNT][PAT_SLOTS] = '{
      '{8'h3C, 8'h62, 8'h72, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00, 8'h00},
      '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B, 8'h00, 8'h00},
      '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00, 8'h00}
   };
   localparam logic [2:0] PAT_LEN [PAT_COUNT] = '{3'd4, 3'd5, 3'd6, 3'd4, 3'd4, 3'd6};
   localparam logic [7:0] PAT_OUT [PAT_COUNT] = '{8'h0A, 8'h26, 8'h20, 8'h3C, 8'h3E, 8'h22};

   localparam logic [PAT_COUNT-1:0] ALL_CANDIDATES = '1;

   // Register byte addresses
   localparam logic [2:0] ADDR_STRIP_ENABLE  = 3'd0;
   localparam logic [2:0] ADDR_ENTITY_ENABLE = 3'd4;

   typedef struct packed {
      logic strip_enable;
      logic entity_enable;
   } cfg_type;

   typedef struct packed {
      logic                 body_mode;
      logic                 last_was_newline;
      logic                 inside_tag;
      logic                 inside_entity;
      logic [2:0]           buffer_length;
      logic [PAT_COUNT-1:0] pattern_candidates;
   } state_type;

   localparam state_type STATE_CLEAR = '{
      body_mode:          1'b0,
      last_was_newline:   1'b0,
      inside_tag:         1'b0,
      inside_entity:      1'b0,
      buffer_length:      3'd0,
      pattern_candidates: ALL_CANDIDATES
   };

endpackage

`default_nettype wire

>>> src/html_tag_stripper.sv
// HTML tag stripper: one message byte in, zero or one byte out, per word.
// Each word passes from the input register stage through hts_core to the result register.
// Throughput: one word per cycle unless rsp_stall holds a full result register.
// Reset (synchronous, active high): clears both pipeline valids, the match
// state and both enable registers; no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module html_tag_stripper (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_msg_start,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [7:0]  rsp_out_byte,
   // configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   hts_pkg::cfg_type   cfg;

   // Input register stage
   logic               s1_valid_ff, s1_valid_in;
   logic [7:0]         s1_byte_ff;
   logic               s1_start_ff;

   // Result register stage
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff;

   // Per-message match state
   hts_pkg::state_type state_ff;
   hts_pkg::state_type state_in;

   logic               core_emit;
   logic [7:0]         core_byte;
   logic               advance;
   logic               req_take;

   hts_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hts_core u_core (
      .cfg       (cfg),
      .state_cur (state_ff),
      .in_byte   (s1_byte_ff),
      .msg_start (s1_start_ff),
      .state_nxt (state_in),
      .emit      (core_emit),
      .out_byte  (core_byte)
   );

   // The result register drains or is empty: the input stage may move on.
   assign advance   = !out_valid_ff || !rsp_stall;
   // Stall only when the input stage holds a word that cannot move.
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Load the result register whenever it moves; words with no result leave it empty.
   assign out_valid_in = advance ? (s1_valid_ff && core_emit) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= hts_pkg::STATE_CLEAR;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         // Advance the match state only as a word is consumed
         if (s1_valid_ff && advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_in_byte;
         s1_start_ff <= req_msg_start;
      end
      if (advance) begin
         out_byte_ff <= core_byte;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;

   // Pass-through mode must reproduce the consumed byte unchanged.
   `HTS_ASSERT_NEXT(a_pass_through, clock, reset,
      s1_valid_ff && advance && !cfg.strip_enable,
      out_valid_ff && out_byte_ff == $past(s1_byte_ff),
      "pass-through byte altered or lost")

   // A stall is raised only behind a full, stalled result register.
   `HTS_ASSERT_NOW(a_stall_cause, clock, reset,
      req_stall,
      s1_valid_ff && out_valid_ff && rsp_stall,
      "input stalled without back-pressure")

   // A message start on a plain byte leaves no open tag or entity behind.
   `HTS_ASSERT_NEXT(a_msg_start_clears, clock, reset,
      s1_valid_ff && advance && s1_start_ff && s1_byte_ff != hts_pkg::CHR_LT
         && s1_byte_ff != hts_pkg::CHR_AMP,
      !state_ff.inside_tag && !state_ff.inside_entity,
      "message start did not clear tag or entity state")

endmodule

`default_nettype wire

>>> src/hts_csr.sv
// APB-style register file of the tag stripper: strip and entity enables.
// Depends on hts_pkg.
`default_nettype none

module hts_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            psel,
   input  wire logic            penable,
   input  wire logic            pwrite,
   input  wire logic [2:0]      paddr,
   input  wire logic [31:0]     pwdata,
   output logic      [31:0]     prdata,
   output logic                 pready,
   output hts_pkg::cfg_type     cfg
);

   hts_pkg::cfg_type cfg_ff;
   hts_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr)
            hts_pkg::ADDR_STRIP_ENABLE:  cfg_in.strip_enable  = pwdata[0];
            hts_pkg::ADDR_ENTITY_ENABLE: cfg_in.entity_enable = pwdata[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (paddr)
         hts_pkg::ADDR_STRIP_ENABLE:  prdata = {31'd0, cfg_ff.strip_enable};
         hts_pkg::ADDR_ENTITY_ENABLE: prdata = {31'd0, cfg_ff.entity_enable};
         default:                     prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> src/hts_core.sv
// Per-byte decision logic: pass-through, header pass, tag and entity tracking, pattern match.
// Pure combinational; depends on hts_pkg.
`default_nettype none

module hts_core (
   input  wire hts_pkg::cfg_type   cfg,
   input  wire hts_pkg::state_type state_cur,
   input  wire logic [7:0]         in_byte,
   input  wire logic               msg_start,
   output hts_pkg::state_type      state_nxt,
   output logic                    emit,
   output logic [7:0]              out_byte
);

   hts_pkg::state_type               st;
   logic                             in_body;
   logic                             opens;
   logic [7:0]                       lc;
   logic [2:0]                       len0;
   logic [2:0]                       len1;
   logic [hts_pkg::PAT_COUNT-1:0]    cand0;
   logic [hts_pkg::PAT_COUNT-1:0]    cand1;

   // Fold A-Z to lower case for matching
   assign lc = (in_byte >= hts_pkg::CHR_UC_A && in_byte <= hts_pkg::CHR_UC_Z) ?
               (in_byte | hts_pkg::CASE_BIT) : in_byte;

   always_comb begin
      st        = msg_start ? hts_pkg::STATE_CLEAR : state_cur;
      state_nxt = st;
      emit      = 1'b0;
      out_byte  = in_byte;
      in_body   = 1'b0;
      opens     = 1'b0;
      len0      = 3'd0;
      len1      = 3'd0;
      cand0     = hts_pkg::ALL_CANDIDATES;
      cand1     = hts_pkg::ALL_CANDIDATES;

      if (!cfg.strip_enable) begin
         emit = 1'b1;
      end else begin
         in_body = st.body_mode;
         if (!st.body_mode) begin
            if (st.last_was_newline && in_byte == hts_pkg::CHR_NL) begin
               state_nxt.body_mode = 1'b1;
               in_body             = 1'b1;
            end else begin
               state_nxt.last_was_newline = (in_byte == hts_pkg::CHR_NL);
               emit                       = 1'b1;
            end
         end

         if (in_body) begin
            // Openers restart the held text
            if (in_byte == hts_pkg::CHR_LT) begin
               state_nxt.inside_tag = 1'b1;
               opens                = 1'b1;
            end
            if (in_byte == hts_pkg::CHR_AMP && cfg.entity_enable) begin
               state_nxt.inside_entity = 1'b1;
               opens                   = 1'b1;
            end
            len0  = opens ? 3'd0 : st.buffer_length;
            cand0 = opens ? hts_pkg::ALL_CANDIDATES : st.pattern_candidates;

            if (!state_nxt.inside_tag && !state_nxt.inside_entity) begin
               emit = 1'b1;
            end else begin
               cand1 = cand0;
               for (int k = 0; k < hts_pkg::PAT_COUNT; k++) begin
                  if (len0 >= hts_pkg::PAT_LEN[k] || hts_pkg::PAT_TEXT[k][len0] != lc) begin
                     cand1[k] = 1'b0;
                  end
               end
               len1 = (len0 == hts_pkg::LEN_MAX) ? len0 : len0 + 3'd1;
            end

            if (in_byte == hts_pkg::CHR_GT) begin
               state_nxt.inside_tag = 1'b0;
               if (cand1[hts_pkg::PAT_BR] && len1 == hts_pkg::PAT_LEN[hts_pkg::PAT_BR]) begin
                  out_byte = hts_pkg::PAT_OUT[hts_pkg::PAT_BR];
                  emit     = 1'b1;
               end
               len1  = 3'd0;
               cand1 = hts_pkg::ALL_CANDIDATES;
            end

            if (in_byte == hts_pkg::CHR_SEMI && cfg.entity_enable) begin
               state_nxt.inside_entity = 1'b0;
               for (int k = 1; k < hts_pkg::PAT_COUNT; k++) begin
                  if (cand1[k] && len1 == hts_pkg::PAT_LEN[k]) begin
                     out_byte = hts_pkg::PAT_OUT[k];
                     emit     = 1'b1;
                  end
               end
               len1  = 3'd0;
               cand1 = hts_pkg::ALL_CANDIDATES;
            end

            state_nxt.buffer_length      = len1;
            state_nxt.pattern_candidates = cand1;
         end
      end
   end

endmodule

`default_nettype wire
